@@ src/triangle_unit_normal_top_defines.svh @@
// ----------------------------------------------------------------------------
// Triangle unit normal assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_UNIT_NORMAL_TOP_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TUN_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tun port check failed");

// Next-cycle implication, disabled during reset.
`define TUN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tun port check failed");

`endif

@@ src/tun_pkg.sv @@
// ----------------------------------------------------------------------------
// Triangle unit normal package
// Constants shared by the datapath and the port checker.
// ----------------------------------------------------------------------------
package tun_pkg;

   // Width of each normal component on the result channel.
   localparam int OUT_WIDTH = 16;

endpackage

@@ src/tun_step.sv @@
// ----------------------------------------------------------------------------
// Triangle unit normal root step
// One registered bit decision of the rounded quotient for all three components.
// ----------------------------------------------------------------------------
module tun_step import tun_pkg::*; #(
   parameter int RW  = 134,
   parameter int PW  = 120,
   parameter int SW  = 102,
   parameter int KW  = 15,
   parameter int BIT = 0
) (
   input  logic          clock,
   input  logic          en,
   input  logic [RW-1:0] r_i [3],
   input  logic [PW-1:0] p_i [3],
   input  logic [KW-1:0] k_i [3],
   input  logic [SW-1:0] s_i,
   input  logic [2:0]    neg_i,
   input  logic          zero_i,
   output logic [RW-1:0] r_ff [3],
   output logic [PW-1:0] p_ff [3],
   output logic [KW-1:0] k_ff [3],
   output logic [SW-1:0] s_ff,
   output logic [2:0]    neg_ff,
   output logic          zero_ff
);

   logic [RW-1:0] r_in [3];
   logic [PW-1:0] p_in [3];
   logic [KW-1:0] k_in [3];

   // The remainder holds L - m*m*S and the partial holds m*S, where m = 2k-1.
   always_comb begin
      logic [RW-1:0] p_ext;
      logic [RW-1:0] trial;
      for (int i = 0; i < 3; i++) begin
         p_ext = {{(RW-PW){p_i[i][PW-1]}}, p_i[i]};
         trial = r_i[i] - (p_ext << (BIT + 2)) - (RW'(s_i) << (2 * BIT + 2));
         if (!trial[RW-1]) begin
            r_in[i] = trial;
            p_in[i] = p_i[i] + (PW'(s_i) << (BIT + 1));
            k_in[i] = k_i[i] | (KW'(1) << BIT);
         end else begin
            r_in[i] = r_i[i];
            p_in[i] = p_i[i];
            k_in[i] = k_i[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            r_ff[i] <= r_in[i];
            p_ff[i] <= p_in[i];
            k_ff[i] <= k_in[i];
         end
         s_ff    <= s_i;
         neg_ff  <= neg_i;
         zero_ff <= zero_i;
      end
   end

endmodule

@@ src/triangle_unit_normal_top.sv @@
// ----------------------------------------------------------------------------
// Triangle unit normal
// Unit face normal of a triangle from three fixed point vertices.
// ----------------------------------------------------------------------------
//   Channel   Ports    Beat contents
//   input     req_*    three vertices, nine signed coordinates
//   result    rsp_*    three Q1.14 normal components and a degenerate flag
//
// One beat enters per cycle unless a result stall backs up to the input.
// Eight stages form edges, cross product, squares and the squared length,
// then one stage per result bit resolves the rounded components.
// Reset clears only the stage valid bits.
// A stall freezes only the stages that are full up to the first empty one.
module triangle_unit_normal_top import tun_pkg::*; #(
   parameter int COORD_WIDTH      = 24,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_p1_x,
   input  logic signed [COORD_WIDTH-1:0] req_p1_y,
   input  logic signed [COORD_WIDTH-1:0] req_p1_z,
   input  logic signed [COORD_WIDTH-1:0] req_p2_x,
   input  logic signed [COORD_WIDTH-1:0] req_p2_y,
   input  logic signed [COORD_WIDTH-1:0] req_p2_z,
   input  logic signed [COORD_WIDTH-1:0] req_p3_x,
   input  logic signed [COORD_WIDTH-1:0] req_p3_y,
   input  logic signed [COORD_WIDTH-1:0] req_p3_z,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [OUT_WIDTH-1:0]  rsp_normal_x,
   output logic signed [OUT_WIDTH-1:0]  rsp_normal_y,
   output logic signed [OUT_WIDTH-1:0]  rsp_normal_z,
   output logic                         rsp_degenerate
);

   localparam int CW    = COORD_WIDTH;
   localparam int NF    = NORMAL_FRAC_BITS;
   localparam int EW    = CW + 1;
   localparam int PRW   = 2 * EW;
   localparam int VW    = PRW + 1;
   localparam int MW    = PRW;
   localparam int HW    = (MW + 1) / 2;
   localparam int LW    = MW - HW;
   localparam int SQW   = 2 * MW;
   localparam int SW    = SQW + 2;
   localparam int KW    = NF + 1;
   localparam int RW    = SW + 2 * NF + 6;
   localparam int PW    = SW + NF + 4;
   localparam int NSTEP = NF + 1;
   localparam int NS    = 8 + NSTEP + 1;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] en;

   always_comb begin
      en[NS-1] = !vld_ff[NS-1] || rsp_ready;
      for (int s = NS - 2; s >= 0; s--) begin
         en[s] = !vld_ff[s] || en[s+1];
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int s = 1; s < NS; s++) begin
            if (en[s]) begin
               vld_ff[s] <= vld_ff[s-1];
            end
         end
      end
   end

   logic signed [EW-1:0]  e1_ff [3];
   logic signed [EW-1:0]  e2_ff [3];
   logic signed [PRW-1:0] a_ff [3];
   logic signed [PRW-1:0] b_ff [3];
   logic signed [VW-1:0]  v_ff [3];
   logic [MW-1:0]         mag_in [3];
   logic [MW-1:0]         mag_ff [3];
   logic [2:0]            neg3_ff;
   logic [2*HW-1:0]       hh_ff [3];
   logic [HW+LW-1:0]      hl_ff [3];
   logic [2*LW-1:0]       ll_ff [3];
   logic [2:0]            neg4_ff;
   logic [SQW-1:0]        sq5_ff [3];
   logic [2:0]            neg5_ff;
   logic [SQW-1:0]        sq6_ff [3];
   logic [SW-1:0]         s6_ff;
   logic [2:0]            neg6_ff;

   logic [RW-1:0] r_st [NSTEP+1][3];
   logic [PW-1:0] p_st [NSTEP+1][3];
   logic [KW-1:0] k_st [NSTEP+1][3];
   logic [SW-1:0] s_st [NSTEP+1];
   logic [2:0]    neg_st [NSTEP+1];
   logic          zero_st [NSTEP+1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = v_ff[i][VW-1] ? MW'(-v_ff[i]) : MW'(v_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         e1_ff[0] <= EW'(req_p2_x) - EW'(req_p1_x);
         e1_ff[1] <= EW'(req_p2_y) - EW'(req_p1_y);
         e1_ff[2] <= EW'(req_p2_z) - EW'(req_p1_z);
         e2_ff[0] <= EW'(req_p3_x) - EW'(req_p1_x);
         e2_ff[1] <= EW'(req_p3_y) - EW'(req_p1_y);
         e2_ff[2] <= EW'(req_p3_z) - EW'(req_p1_z);
      end
      if (en[1]) begin
         a_ff[0] <= e1_ff[1] * e2_ff[2];
         b_ff[0] <= e1_ff[2] * e2_ff[1];
         a_ff[1] <= e1_ff[2] * e2_ff[0];
         b_ff[1] <= e1_ff[0] * e2_ff[2];
         a_ff[2] <= e1_ff[0] * e2_ff[1];
         b_ff[2] <= e1_ff[1] * e2_ff[0];
      end
      if (en[2]) begin
         for (int i = 0; i < 3; i++) begin
            v_ff[i] <= VW'(a_ff[i]) - VW'(b_ff[i]);
         end
      end
      if (en[3]) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[i]  <= mag_in[i];
            neg3_ff[i] <= v_ff[i][VW-1];
         end
      end
      if (en[4]) begin
         for (int i = 0; i < 3; i++) begin
            hh_ff[i] <= mag_ff[i][MW-1:LW] * mag_ff[i][MW-1:LW];
            hl_ff[i] <= mag_ff[i][MW-1:LW] * mag_ff[i][LW-1:0];
            ll_ff[i] <= mag_ff[i][LW-1:0] * mag_ff[i][LW-1:0];
         end
         neg4_ff <= neg3_ff;
      end
      if (en[5]) begin
         for (int i = 0; i < 3; i++) begin
            sq5_ff[i] <= (SQW'(hh_ff[i]) << (2 * LW)) + (SQW'(hl_ff[i]) << (LW + 1))
                         + SQW'(ll_ff[i]);
         end
         neg5_ff <= neg4_ff;
      end
      if (en[6]) begin
         sq6_ff  <= sq5_ff;
         s6_ff   <= SW'(sq5_ff[0]) + SW'(sq5_ff[1]) + SW'(sq5_ff[2]);
         neg6_ff <= neg5_ff;
      end
   end

   // Stage seven starts the search with k = 0, so m = -1, R = L - S and P = -S.
   logic [RW-1:0] r7_ff [3];
   logic [PW-1:0] p7_ff [3];
   logic [KW-1:0] k7_ff [3];
   logic [SW-1:0] s7_ff;
   logic [2:0]    neg7_ff;
   logic          zero7_ff;

   always_ff @(posedge clock) begin
      if (en[7]) begin
         for (int i = 0; i < 3; i++) begin
            r7_ff[i] <= (RW'(sq6_ff[i]) << (2 * NF + 2)) - RW'(s6_ff);
            p7_ff[i] <= PW'(0) - PW'(s6_ff);
            k7_ff[i] <= '0;
         end
         s7_ff    <= s6_ff;
         neg7_ff  <= neg6_ff;
         zero7_ff <= (s6_ff == '0);
      end
   end

   assign r_st[0]    = r7_ff;
   assign p_st[0]    = p7_ff;
   assign k_st[0]    = k7_ff;
   assign s_st[0]    = s7_ff;
   assign neg_st[0]  = neg7_ff;
   assign zero_st[0] = zero7_ff;

   for (genvar g = 0; g < NSTEP; g++) begin : g_step
      tun_step #(
         .RW  (RW),
         .PW  (PW),
         .SW  (SW),
         .KW  (KW),
         .BIT (NF - g)
      ) u_step (
         .clock   (clock),
         .en      (en[8+g]),
         .r_i     (r_st[g]),
         .p_i     (p_st[g]),
         .k_i     (k_st[g]),
         .s_i     (s_st[g]),
         .neg_i   (neg_st[g]),
         .zero_i  (zero_st[g]),
         .r_ff    (r_st[g+1]),
         .p_ff    (p_st[g+1]),
         .k_ff    (k_st[g+1]),
         .s_ff    (s_st[g+1]),
         .neg_ff  (neg_st[g+1]),
         .zero_ff (zero_st[g+1])
      );
   end

   logic [OUT_WIDTH-1:0] mag_out [3];
   logic [OUT_WIDTH-1:0] nrm_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_out[i] = OUT_WIDTH'(k_st[NSTEP][i]);
         if (zero_st[NSTEP]) begin
            nrm_in[i] = '0;
         end else if (neg_st[NSTEP][i]) begin
            nrm_in[i] = OUT_WIDTH'(0) - mag_out[i];
         end else begin
            nrm_in[i] = mag_out[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         rsp_normal_x   <= nrm_in[0];
         rsp_normal_y   <= nrm_in[1];
         rsp_normal_z   <= nrm_in[2];
         rsp_degenerate <= zero_st[NSTEP];
      end
   end

endmodule

@@ src/tun_checker.sv @@
// ----------------------------------------------------------------------------
// Triangle unit normal port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
`include "triangle_unit_normal_top_defines.svh"

module tun_checker import tun_pkg::*; (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic signed [OUT_WIDTH-1:0] rsp_normal_x,
   input logic signed [OUT_WIDTH-1:0] rsp_normal_y,
   input logic signed [OUT_WIDTH-1:0] rsp_normal_z,
   input logic                        rsp_degenerate
);

   // A stalled result beat keeps its contents.
   `TUN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_normal_x) && $stable(rsp_normal_y)
      && $stable(rsp_normal_z) && $stable(rsp_degenerate))

   // A degenerate triangle reports a zero normal.
   `TUN_ASSERT_NOW(a_degen_zero, clock, reset, rsp_valid && rsp_degenerate,
      rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0)

   // A proper triangle has a unit normal, so some component is nonzero.
   `TUN_ASSERT_NOW(a_proper_nonzero, clock, reset, rsp_valid && !rsp_degenerate,
      rsp_normal_x != '0 || rsp_normal_y != '0 || rsp_normal_z != '0)

endmodule

bind triangle_unit_normal_top tun_checker u_tun_checker (.*);

@@ tb/triangle_unit_normal_top_tb.sv @@
// ----------------------------------------------------------------------------
// Triangle unit normal testbench
// Drives triangles through the input channel and checks every result beat
// against a listed expected normal or a bit-exact predictor of the rounded
// unit normal, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module triangle_unit_normal_top_tb import tun_pkg::*;;

   localparam int CW = 24;
   localparam int FB = 14;
   localparam int N_RANDOM = 530;
   localparam int QUIET_TAIL = 80;
   localparam int CYCLE_LIMIT = 200000;

   typedef logic signed [CW-1:0] coord_type;
   typedef struct {
      coord_type c[9];
   } tri_type;
   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] nx;
      logic signed [OUT_WIDTH-1:0] ny;
      logic signed [OUT_WIDTH-1:0] nz;
      logic degen;
   } normal_type;
   typedef struct {
      tri_type t;
      bit typed;
      normal_type n;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   coord_type req_p1_x = '0, req_p1_y = '0, req_p1_z = '0;
   coord_type req_p2_x = '0, req_p2_y = '0, req_p2_z = '0;
   coord_type req_p3_x = '0, req_p3_y = '0, req_p3_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [OUT_WIDTH-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic rsp_degenerate;

   normal_type pending_normals[$];
   int mismatches = 0;
   int cycles = 0;
   bit quiet = 1'b0;
   int ready_gap = 0;
   row_type rows[$];

   triangle_unit_normal_top i_dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic [15:0] rounded_component(longint v, logic [159:0] s);
      logic [159:0] mag, lhs, rhs;
      longint lo, hi, mid, t;
      mag = 160'(v < 0 ? -v : v);
      lhs = (mag * mag) << (2 * FB + 2);
      lo = 0;
      hi = 1 << FB;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         t = 2 * mid - 1;
         rhs = s * 160'(t * t);
         if (rhs <= lhs) lo = mid;
         else hi = mid - 1;
      end
      return (v < 0) ? 16'(-lo) : 16'(lo);
   endfunction

   function automatic normal_type unit_normal(tri_type t);
      longint e1[3], e2[3], v[3];
      logic [159:0] s;
      normal_type n;
      for (int i = 0; i < 3; i++) begin
         e1[i] = longint'(t.c[3+i]) - longint'(t.c[i]);
         e2[i] = longint'(t.c[6+i]) - longint'(t.c[i]);
      end
      for (int i = 0; i < 3; i++)
         v[i] = e1[(i+1)%3] * e2[(i+2)%3] - e1[(i+2)%3] * e2[(i+1)%3];
      s = '0;
      for (int i = 0; i < 3; i++)
         s = s + 160'(v[i] < 0 ? -v[i] : v[i]) * 160'(v[i] < 0 ? -v[i] : v[i]);
      if (s == 0) begin
         n = '{nx: '0, ny: '0, nz: '0, degen: 1'b1};
      end else begin
         n.nx = rounded_component(v[0], s);
         n.ny = rounded_component(v[1], s);
         n.nz = rounded_component(v[2], s);
         n.degen = 1'b0;
      end
      return n;
   endfunction

   function automatic tri_type mk(int a0, int a1, int a2, int b0, int b1, int b2,
                                  int c0, int c1, int c2);
      tri_type t;
      t.c = '{coord_type'(a0), coord_type'(a1), coord_type'(a2), coord_type'(b0),
              coord_type'(b1), coord_type'(b2), coord_type'(c0), coord_type'(c1),
              coord_type'(c2)};
      return t;
   endfunction

   function automatic tri_type random_triangle();
      tri_type t;
      int mode, k, span;
      mode = $urandom_range(0, 9);
      span = (mode < 6) ? (1 << $urandom_range(1, 16)) : 8192;
      for (int i = 0; i < 9; i++) begin
         if (mode < 3) t.c[i] = coord_type'($urandom);
         else t.c[i] = coord_type'($urandom_range(0, 2 * span) - span);
      end
      if (mode == 8) begin
         k = $urandom_range(0, 6) - 3;
         for (int i = 0; i < 3; i++)
            t.c[6+i] = t.c[i] + coord_type'(k) * (t.c[3+i] - t.c[i]);
      end else if (mode == 9) begin
         for (int i = 0; i < 3; i++) begin
            t.c[3+i] = t.c[i];
            if ($urandom_range(0, 1)) t.c[6+i] = t.c[i];
         end
      end
      return t;
   endfunction

   task automatic send_beat(tri_type t, bit typed, normal_type n, bit may_idle);
      int gap;
      if (may_idle && !quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_p1_x, req_p1_y, req_p1_z} <= {t.c[0], t.c[1], t.c[2]};
      {req_p2_x, req_p2_y, req_p2_z} <= {t.c[3], t.c[4], t.c[5]};
      {req_p3_x, req_p3_y, req_p3_z} <= {t.c[6], t.c[7], t.c[8]};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_normals.push_back(typed ? n : unit_normal(t));
   endtask

   always @(posedge clock) begin
      normal_type want, got;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{nx: rsp_normal_x, ny: rsp_normal_y, nz: rsp_normal_z,
                    degen: rsp_degenerate};
            if (pending_normals.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result beat %p", got);
            end else begin
               want = pending_normals.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
               end
            end
         end
         if (ready_gap > 0) begin
            ready_gap <= ready_gap - 1;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            ready_gap <= $urandom_range(0, 7);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      normal_type none, deg;
      none = '0;
      deg = '{nx: '0, ny: '0, nz: '0, degen: 1'b1};
      rows.push_back('{mk(0,0,0, 0,0,0, 0,0,0), 1, deg});
      rows.push_back('{mk(0,0,0, 4096,0,0, 0,4096,0), 1, '{0, 0, 16384, 0}});
      rows.push_back('{mk(0,0,0, 0,4096,0, 0,0,4096), 1, '{16384, 0, 0, 0}});
      rows.push_back('{mk(0,0,0, 0,0,4096, 4096,0,0), 1, '{0, 16384, 0, 0}});
      rows.push_back('{mk(0,0,0, 0,4096,0, 4096,0,0), 1, '{0, 0, -16384, 0}});
      rows.push_back('{mk(0,0,0, 1,0,0, 0,1,0), 1, '{0, 0, 16384, 0}});
      rows.push_back('{mk(-8388608,-8388608,-8388608, 8388607,-8388608,-8388608,
                          -8388608,8388607,-8388608), 1, '{0, 0, 16384, 0}});
      rows.push_back('{mk(8388607,8388607,8388607, -8388608,8388607,8388607,
                          8388607,-8388608,8388607), 1, '{0, 0, 16384, 0}});
      rows.push_back('{mk(8388607,8388607,8388607, 8388607,8388607,8388607,
                          8388607,8388607,8388607), 1, deg});
      rows.push_back('{mk(-8388608,-8388608,-8388608, -8388608,-8388608,-8388608,
                          -8388608,-8388608,-8388608), 1, deg});
      rows.push_back('{mk(0,0,0, 1,1,1, 2,2,2), 1, deg});
      rows.push_back('{mk(5,-7,9, 5,-7,9, 100,200,300), 1, deg});
      rows.push_back('{mk(0,0,0, 1,0,0, 0,1,1), 0, none});
      rows.push_back('{mk(-8388608,8388607,0, 8388607,-8388608,1, 3,-5,8388607), 0, none});
      rows.push_back('{mk(8388607,-8388608,8388607, -8388608,8388607,-8388608,
                          8388607,8388607,-8388608), 0, none});
      rows.push_back('{mk(1,2,3, -4,5,-6, 7,-8,9), 0, none});
      rows.push_back('{mk(-1,-1,-1, 0,0,0, -1,0,-1), 0, none});

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_beat(rows[i].t, rows[i].typed, rows[i].n, 1'b1);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_normals.size() != 0) @(posedge clock);

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM - QUIET_TAIL) quiet = 1'b1;
         send_beat(random_triangle(), 1'b0, none, 1'b1);
      end
      req_valid <= 1'b0;

      while (pending_normals.size() != 0) @(posedge clock);
      repeat (FB + 20) @(posedge clock);
      if (mismatches == 0 && pending_normals.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
